// File: src/svb_pkg.sv
// Shared types, constants and saturation helper for the skinned vertex blend.
// No dependencies; every other file of the block imports it.
package svb_pkg;
	localparam int MAX_BONES      = 64;
	localparam int WORDS_PER_BONE = 12;
	localparam int ROWS           = 3;
	localparam int LANES          = 4;
	localparam int BONE_W         = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int IDX_W          = 9;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SKIN = 1'b1;

	// One matrix word write, broadcast to every bone lane
	typedef struct packed {
		logic        en;
		logic [5:0]  slot;
		logic [3:0]  elem;
		logic [31:0] value;
	} svb_load_t;

	// Saturate a wide signed value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage

// File: src/svb_bone_store.sv
// One lane's copy of the bone matrix table: twelve word banks with per-bone valid bits.
// Depends on svb_pkg.
module svb_bone_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  svb_pkg::svb_load_t       ld,
	input  logic                     en,
	input  logic [svb_pkg::BONE_W-1:0] raddr,
	input  logic                     rd_zero,
	output logic signed [31:0]       words [svb_pkg::WORDS_PER_BONE]
);
	import svb_pkg::*;

	logic [31:0]          mem [WORDS_PER_BONE][MAX_BONES];
	logic [MAX_BONES-1:0] valid_q;
	logic [31:0]          rd_s1 [WORDS_PER_BONE];
	logic                 zero_s1;
	logic [7:0]           slot8;
	logic [BONE_W-1:0]    waddr;

	assign slot8 = {2'b00, ld.slot};
	assign waddr = slot8[BONE_W-1:0];

	// Mark a bone valid on its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (ld.en)
			valid_q[waddr] <= 1'b1;
	end

	// First write to a bone fills its whole row, the other words with zero
	always_ff @(posedge clk) begin
		for (int e = 0; e < WORDS_PER_BONE; e++) begin
			if (ld.en && (!valid_q[waddr] || ld.elem == 4'(e)))
				mem[e][waddr] <= (ld.elem == 4'(e)) ? ld.value : 32'd0;
		end
		if (en) begin
			for (int e = 0; e < WORDS_PER_BONE; e++)
				rd_s1[e] <= mem[e][raddr];
			zero_s1 <= rd_zero || !valid_q[raddr];
		end
	end

	// Unwritten or out-of-range bones read as zero
	always_comb begin
		for (int e = 0; e < WORDS_PER_BONE; e++)
			words[e] = zero_s1 ? 32'sd0 : signed'(rd_s1[e]);
	end
endmodule

// File: src/svb_row_xform.sv
// Affine transform of the position by one bone matrix: products, then row sums.
// Depends on svb_pkg.
module svb_row_xform (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] mats [svb_pkg::WORDS_PER_BONE],
	input  logic signed [31:0] pos  [svb_pkg::ROWS],
	output logic signed [31:0] t_s3 [svb_pkg::ROWS]
);
	import svb_pkg::*;

	logic signed [63:0] prod_s2 [ROWS][ROWS];
	logic signed [31:0] trans_s2 [ROWS];
	logic signed [65:0] sum [ROWS];
	logic signed [50:0] row [ROWS];

	// Form the nine products and hold the translation column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < ROWS; c++)
					prod_s2[r][c] <= mats[r*4+c] * pos[c];
				trans_s2[r] <= mats[r*4+3];
			end
		end
	end

	// Sum, floor to Q16.16, add translation
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			sum[r] = 66'(prod_s2[r][0]) + 66'(prod_s2[r][1]) + 66'(prod_s2[r][2]);
			row[r] = 51'(sum[r] >>> 16) + 51'(trans_s2[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < ROWS; r++)
				t_s3[r] <= sat32(64'(row[r]));
		end
	end
endmodule

// File: src/svb_blend.sv
// Weighted blend of the four per-bone positions, floor and saturation to Q16.16.
// Depends on svb_pkg.
module svb_blend (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] t_s3 [svb_pkg::LANES][svb_pkg::ROWS],
	input  logic signed [19:0] w_s3 [svb_pkg::LANES],
	output logic signed [31:0] res_s5 [svb_pkg::ROWS]
);
	import svb_pkg::*;

	logic signed [51:0] prod_s4 [LANES][ROWS];
	logic signed [53:0] acc [ROWS];

	// Weight each transformed row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++)
				for (int r = 0; r < ROWS; r++)
					prod_s4[k][r] <= t_s3[k][r] * w_s3[k];
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++)
			acc[r] = 54'(prod_s4[0][r]) + 54'(prod_s4[1][r])
				+ 54'(prod_s4[2][r]) + 54'(prod_s4[3][r]);
	end

	// Floor to Q16.16 and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < ROWS; r++)
				res_s5[r] <= sat32(64'(acc[r] >>> 16));
		end
	end
endmodule

// File: src/skinned_vertex_blend.sv
// Top level of the four-bone linear blend skinning pipeline.
// Depends on svb_pkg, svb_bone_store, svb_row_xform and svb_blend.
//
//  channel | handshake          | payload
//  input   | in_valid, in_stall | command, pos_*, weight_*, bone_indices, load_*
//  output  | out_valid,out_stall| skinned_x/y/z, index_error
//
// One transfer per cycle on each side while the output is not stalled; five register stages:
// table read, products, row sums, weighted products, blend sum. The first stage loads at the
// edge that takes a skin item, and its result is offered from the blend sum register.
// Load items with an element below twelve write the table at once and give no result.
// Reset clears the valid bits; a bone never written reads as zero.
// A stalled result freezes the whole pipeline; input is stalled only then.
module skinned_vertex_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [16:0]        weight_first,
	input  logic [16:0]        weight_second,
	input  logic [16:0]        weight_third,
	input  logic [35:0]        bone_indices,
	input  logic [5:0]         load_slot,
	input  logic [3:0]         load_element,
	input  logic signed [31:0] load_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] skinned_x,
	output logic signed [31:0] skinned_y,
	output logic signed [31:0] skinned_z,
	output logic               index_error
);
	import svb_pkg::*;

	logic               adv;
	logic               take;
	svb_load_t          ld;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               err_s1, err_s2, err_s3, err_s4, err_s5;
	logic [18:0]        wsum;
	logic signed [19:0] w_in [LANES];
	logic signed [19:0] w_s1 [LANES];
	logic signed [19:0] w_s2 [LANES];
	logic signed [19:0] w_s3 [LANES];
	logic signed [31:0] pos_s1 [ROWS];
	logic [IDX_W-1:0]   f [LANES];
	logic [BONE_W-1:0]  raddr [LANES];
	logic [LANES-1:0]   over;
	logic signed [31:0] mats [LANES][WORDS_PER_BONE];
	logic signed [31:0] t_s3 [LANES][ROWS];
	logic signed [31:0] res_s5 [ROWS];

	assign adv      = !(v_s5 && out_stall);
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	// Decode the table write of a load transfer
	assign ld.en    = take && command == CMD_LOAD && {3'b000, load_slot} < 9'(MAX_BONES)
		&& load_element < 4'(WORDS_PER_BONE);
	assign ld.slot  = load_slot;
	assign ld.elem  = load_element;
	assign ld.value = load_value;

	// Decode bone indices and the implied fourth weight
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			f[k]     = bone_indices[k*IDX_W +: IDX_W];
			over[k]  = !f[k][IDX_W-1] && f[k] >= 9'(MAX_BONES);
			raddr[k] = f[k][IDX_W-1] ? '0 : f[k][BONE_W-1:0];
		end
		wsum    = 19'(weight_first) + 19'(weight_second) + 19'(weight_third);
		w_in[0] = signed'(20'(weight_first));
		w_in[1] = signed'(20'(weight_second));
		w_in[2] = signed'(20'(weight_third));
		w_in[3] = signed'(20'd65536 - 20'(wsum));
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (adv) begin
			v_s1 <= in_valid && command == CMD_SKIN;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Carry position, weights and error flag alongside the data
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= |over;
			err_s2 <= err_s1;
			err_s3 <= err_s2;
			err_s4 <= err_s3;
			err_s5 <= err_s4;
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			w_s1 <= w_in;
			w_s2 <= w_s1;
			w_s3 <= w_s2;
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		svb_bone_store u_store (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.en      (adv),
			.raddr   (raddr[k]),
			.rd_zero (over[k]),
			.words   (mats[k])
		);

		svb_row_xform u_xform (
			.clk  (clk),
			.en   (adv),
			.mats (mats[k]),
			.pos  (pos_s1),
			.t_s3 (t_s3[k])
		);
	end

	svb_blend u_blend (
		.clk    (clk),
		.en     (adv),
		.t_s3   (t_s3),
		.w_s3   (w_s3),
		.res_s5 (res_s5)
	);

	assign out_valid   = v_s5;
	assign skinned_x   = res_s5[0];
	assign skinned_y   = res_s5[1];
	assign skinned_z   = res_s5[2];
	assign index_error = err_s5;

`ifndef NO_ASSERTIONS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && command == CMD_LOAD |=> !v_s1)
		else $error("load transfer entered the pipeline");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s1 |=> v_s1 && v_s5)
		else $error("stage one lost an item during a stall");
	a_neg_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		take && bone_indices[8] && bone_indices[17] && bone_indices[26]
		&& bone_indices[35] |=> !err_s1)
		else $error("negative indices raised an error");
`endif
endmodule

// File: tb/testbench.sv
// Self-checking testbench for skinned_vertex_blend: matrix word loads and vertex skin transfers.
// Depends on svb_pkg and the skinned_vertex_blend RTL; predicts each skin result in place.
`timescale 1ns / 1ps
module testbench;
	import svb_pkg::*;

	typedef struct {
		logic        command;
		logic [31:0] pos_x, pos_y, pos_z;
		logic [16:0] w1, w2, w3;
		logic [35:0] bone_indices;
		logic [5:0]  load_slot;
		logic [3:0]  load_element;
		logic [31:0] load_value;
	} vertex_cmd_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        err;
	} skinned_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [16:0] weight_first = '0, weight_second = '0, weight_third = '0;
	logic [35:0] bone_indices = '0;
	logic [5:0]  load_slot = '0;
	logic [3:0]  load_element = '0;
	logic signed [31:0] load_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] skinned_x, skinned_y, skinned_z;
	logic index_error;

	vertex_cmd_t  pending_cmds[$];
	skinned_pos_t expected_pos[$];
	logic [31:0]  bone_words[MAX_BONES * WORDS_PER_BONE];
	int  errors = 0;
	int  cycles = 0;
	int  in_gap = 0;
	int  out_gap = 0;
	bit  stim_done = 1'b0;

	skinned_vertex_blend u_top (.*);

	always #1 clk = ~clk;

	// Pick a gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Append one transfer to the stimulus queue
	function automatic void queue_cmd(input vertex_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Transform the position by one row of one bone; bone below 0 reads as zero
	function automatic logic signed [63:0] bone_row_pos(input int bone, input int row,
			input logic signed [63:0] p[3]);
		logic signed [127:0] s;
		s = 0;
		if (bone < 0) return 0;
		for (int c = 0; c < 3; c++)
			s += 128'($signed(bone_words[bone * WORDS_PER_BONE + row * 4 + c])) * p[c];
		s = (s >>> 16) + 128'($signed(bone_words[bone * WORDS_PER_BONE + row * 4 + 3]));
		return sat32(s > 128'sh7FFFFFFF ? 64'sh7FFFFFFF :
			s < -128'sh80000000 ? -64'sh80000000 : 64'(s));
	endfunction

	// Apply one transfer to the bone table or predict its blended position
	task automatic predict_blend(input vertex_cmd_t c);
		logic signed [63:0] p[3];
		logic signed [63:0] w[4];
		logic signed [127:0] acc;
		logic signed [31:0] r[3];
		logic [8:0] f;
		int bone[4];
		skinned_pos_t e;
		if (c.command == CMD_LOAD) begin
			if (c.load_slot < MAX_BONES && c.load_element < WORDS_PER_BONE)
				bone_words[c.load_slot * WORDS_PER_BONE + c.load_element] = c.load_value;
			return;
		end
		p[0] = $signed(c.pos_x); p[1] = $signed(c.pos_y); p[2] = $signed(c.pos_z);
		w[0] = {47'd0, c.w1}; w[1] = {47'd0, c.w2}; w[2] = {47'd0, c.w3};
		w[3] = 64'sd65536 - (w[0] + w[1] + w[2]);
		e.err = 1'b0;
		for (int k = 0; k < 4; k++) begin
			f = c.bone_indices[9 * k +: 9];
			if (f[8]) bone[k] = 0;
			else if (f >= MAX_BONES) begin
				bone[k] = -1;
				e.err = 1'b1;
			end else bone[k] = f;
		end
		for (int row = 0; row < 3; row++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += 128'(bone_row_pos(bone[k], row, p)) * 128'(w[k]);
			acc = acc >>> 16;
			r[row] = acc > 128'sh7FFFFFFF ? 32'sh7FFFFFFF :
				acc < -128'sh80000000 ? -32'sh80000000 : acc[31:0];
		end
		e.x = r[0]; e.y = r[1]; e.z = r[2];
		expected_pos.insert(expected_pos.size(), e);
	endtask

	function automatic vertex_cmd_t make_load(input logic [5:0] s, input logic [3:0] el,
			input logic [31:0] v);
		vertex_cmd_t c;
		c = '{default: '0};
		c.command = CMD_LOAD; c.load_slot = s; c.load_element = el; c.load_value = v;
		c.pos_x = $urandom; c.bone_indices = 36'({$urandom, $urandom});
		return c;
	endfunction

	function automatic logic [31:0] rand_word(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 262144)) - 131072);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	function automatic logic [8:0] rand_index();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return 9'($urandom_range(0, MAX_BONES - 1));
		if (r < 8) return 9'h100 | 9'($urandom);
		return 9'($urandom_range(MAX_BONES, 255));
	endfunction

	function automatic vertex_cmd_t make_skin(input int mode);
		vertex_cmd_t c;
		logic [16:0] a;
		c = '{default: '0};
		c.command = CMD_SKIN;
		c.pos_x = rand_word(mode); c.pos_y = rand_word(mode); c.pos_z = rand_word(mode);
		if ($urandom_range(0, 3) == 0) begin
			c.w1 = 17'($urandom); c.w2 = 17'($urandom); c.w3 = 17'($urandom);
		end else begin
			a = 17'($urandom_range(0, 65536));
			c.w1 = a; c.w2 = 17'($urandom_range(0, 65536 - a));
			c.w3 = 17'($urandom_range(0, 65536 - a - c.w2));
		end
		for (int k = 0; k < 4; k++) c.bone_indices[9 * k +: 9] = rand_index();
		c.load_slot = 6'($urandom); c.load_element = 4'($urandom); c.load_value = $urandom;
		return c;
	endfunction

	// Fill the queue: directed corners, then random loads and skins
	initial begin
		vertex_cmd_t c;
		int mode;
		foreach (bone_words[i]) bone_words[i] = '0;
		c = make_skin(1); c.bone_indices = '0; queue_cmd(c);
		// Identity matrix with x translation -1.0 on bone 0, extremes on bone 63
		queue_cmd(make_load(0, 0, 32'h0001_0000));
		queue_cmd(make_load(0, 5, 32'h0001_0000));
		queue_cmd(make_load(0, 10, 32'h0001_0000));
		queue_cmd(make_load(0, 3, 32'hFFFF_0000));
		queue_cmd(make_load(63, 0, 32'h7FFF_FFFF));
		queue_cmd(make_load(63, 11, 32'h8000_0000));
		queue_cmd(make_load(5, 12, 32'h1234_5678));
		queue_cmd(make_load(5, 15, 32'hFFFF_FFFF));
		c = make_skin(2); c.bone_indices = {9'd63, 9'd0, 9'd63, 9'd0};
		c.w1 = 17'd65536; c.w2 = 0; c.w3 = 0; queue_cmd(c);
		c = make_skin(2); c.bone_indices = {9'h1FF, 9'h100, 9'd63, 9'd63};
		c.w1 = 17'h1FFFF; c.w2 = 17'h1FFFF; c.w3 = 17'h1FFFF; queue_cmd(c);
		c = make_skin(0); c.bone_indices = {9'd255, 9'd64, 9'd1, 9'd0};
		queue_cmd(c);
		c = make_skin(2); c.bone_indices = {9'd63, 9'd63, 9'd63, 9'd63};
		c.w1 = 0; c.w2 = 0; c.w3 = 0; c.pos_x = 32'h7FFF_FFFF; c.pos_y = 32'h8000_0000;
		queue_cmd(c);
		c = make_skin(3); c.bone_indices = {9'd0, 9'd0, 9'd0, 9'h100};
		c.w1 = 17'd16384; c.w2 = 17'd16384; c.w3 = 17'd16384; queue_cmd(c);
		for (int n = 0; n < 1450; n++) begin
			mode = $urandom_range(0, 3);
			if ($urandom_range(0, 2) == 0)
				queue_cmd(make_load($urandom_range(0, 9) == 0 ? 6'($urandom)
					: 6'($urandom_range(0, 7)), $urandom_range(0, 9) == 0 ?
					4'($urandom) : 4'($urandom_range(0, 11)), rand_word(mode)));
			else
				queue_cmd(make_skin(mode));
		end
		stim_done = 1'b1;
	end

	// Hold reset, then release it once
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Drive: advance on a transfer, hold while stalled, insert random gaps
	always @(posedge clk) begin
		vertex_cmd_t c;
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) predict_blend(pending_cmds.pop_front());
				if (in_gap > 0 || pending_cmds.size() == 0) begin
					if (in_gap > 0) in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else begin
					c = pending_cmds[0];
					in_valid <= 1'b1;
					command <= c.command;
					pos_x <= c.pos_x; pos_y <= c.pos_y; pos_z <= c.pos_z;
					weight_first <= c.w1; weight_second <= c.w2; weight_third <= c.w3;
					bone_indices <= c.bone_indices;
					load_slot <= c.load_slot; load_element <= c.load_element;
					load_value <= c.load_value;
					in_gap <= pick_gap();
				end
			end
		end
	end

	// Check each result transfer against the oldest prediction; toggle stall
	always @(posedge clk) begin
		skinned_pos_t e;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pos.size() == 0) begin
					$error("unexpected result x=%h", skinned_x);
					errors = errors + 1;
				end else begin
					e = expected_pos.pop_front();
					if (skinned_x !== e.x) begin
						$error("skinned_x exp %h got %h", e.x, skinned_x);
						errors = errors + 1;
					end
					if (skinned_y !== e.y) begin
						$error("skinned_y exp %h got %h", e.y, skinned_y);
						errors = errors + 1;
					end
					if (skinned_z !== e.z) begin
						$error("skinned_z exp %h got %h", e.z, skinned_z);
						errors = errors + 1;
					end
					if (index_error !== e.err) begin
						$error("index_error exp %b got %b", e.err, index_error);
						errors = errors + 1;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
			end
		end
	end

	// Finish once drained, or on timeout
	initial begin
		fork
			begin
				wait (stim_done && pending_cmds.size() == 0 && !in_valid);
				wait (expected_pos.size() == 0);
				repeat (40) @(posedge clk);
				if (errors == 0 && expected_pos.size() == 0)
					$display("DONE: 0 errors");
				else
					$display("DONE: errors detected");
				$finish;
			end
			begin
				wait (cycles >= 500000);
				$display("DONE: errors detected");
				$finish;
			end
		join
	end
endmodule
